>>> design/clls_pkg.sv
// Package for the curve and lead speed limiter: payload types, register
// indexes, CORDIC table and sequencer states. No dependencies.
package clls_pkg;

	localparam int CordicSteps = 16;
	localparam int GainInv     = 39797;
	localparam int CurveEps    = 8;

	typedef enum logic [1:0] {
		REG_MAX_LAT  = 2'd0,
		REG_HALF_W   = 2'd1,
		REG_TTC      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [23:0] ego_x;
		logic signed [23:0] ego_y;
		logic [15:0]        ego_heading;
		logic [15:0]        ego_speed;
		logic signed [31:0] curve_coef;
		logic [15:0]        speed_cap;
		logic signed [23:0] obstacle_x;
		logic signed [23:0] obstacle_y;
		logic [15:0]        obstacle_speed;
		logic               obstacle_valid;
		logic               frame_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] target_speed;
		logic        lead_found;
		logic        curve_active;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_GAIN,
		ST_TEST,
		ST_TTC,
		ST_LEAD,
		ST_CHECK_LAST,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} state_t;

	function automatic logic [24:0] atan_entry(input logic [3:0] i);
		logic [24:0] r;
		r = '0;
		case (i)
			4'd0:  r = 25'd2097152;
			4'd1:  r = 25'd1238021;
			4'd2:  r = 25'd654136;
			4'd3:  r = 25'd332050;
			4'd4:  r = 25'd166669;
			4'd5:  r = 25'd83416;
			4'd6:  r = 25'd41718;
			4'd7:  r = 25'd20860;
			4'd8:  r = 25'd10430;
			4'd9:  r = 25'd5215;
			4'd10: r = 25'd2608;
			4'd11: r = 25'd1304;
			4'd12: r = 25'd652;
			4'd13: r = 25'd326;
			4'd14: r = 25'd163;
			4'd15: r = 25'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/clls_if.sv
// Valid/ready channel interfaces carrying the packed payloads.
// Depends on clls_pkg for the payload types.
interface clls_in_if;
	import clls_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface clls_out_if;
	import clls_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/clls_divsqrt.sv
// Serial unsigned divider (one quotient bit per cycle) and square root
// (one result bit per cycle). Depends on clls_pkg.
module clls_divsqrt import clls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] accel,
	input  logic [31:0] mag,
	output logic        done,
	output logic [15:0] root
);
	// quotient < 2^47 -> 47 divide steps, then 24 root steps (root < 2^24)
	typedef enum logic [1:0] {DS_IDLE, DS_DIV, DS_SQRT, DS_DONE} ds_t;
	ds_t         st_q;
	logic [5:0]  cnt_q;
	logic [46:0] num_q;
	logic [31:0] rem_q;
	logic [47:0] rad_q;
	logic [25:0] srem_q;
	logic [23:0] res_q;
	logic [32:0] rem_sh;
	logic [25:0] srem_sh;
	logic [25:0] trial;

	always_comb begin
		rem_sh  = {rem_q, num_q[46]};
		srem_sh = {srem_q[23:0], rad_q[47:46]};
		trial   = {res_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DS_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				DS_IDLE: if (start) begin
					st_q  <= DS_DIV;
					cnt_q <= 6'd46;
				end
				DS_DIV: if (cnt_q == 6'd0) begin
					st_q  <= DS_SQRT;
					cnt_q <= 6'd23;
				end else cnt_q <= cnt_q - 6'd1;
				DS_SQRT: if (cnt_q == 6'd0) st_q <= DS_DONE;
					else cnt_q <= cnt_q - 6'd1;
				DS_DONE: st_q <= DS_IDLE;
				default: st_q <= DS_IDLE;
			endcase
		end
	end

	// hold the root after done until the next start
	always_ff @(posedge clk) begin
		case (st_q)
			DS_IDLE: if (start) begin
				num_q  <= {accel, 31'd0};
				rem_q  <= '0;
				rad_q  <= '0;
				srem_q <= '0;
				res_q  <= '0;
			end
			DS_DIV: begin
				num_q <= {num_q[45:0], 1'b0};
				if (rem_sh >= {1'b0, mag}) begin
					rem_q <= 32'(rem_sh - {1'b0, mag});
					rad_q <= {rad_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					rad_q <= {rad_q[46:0], 1'b0};
				end
			end
			DS_SQRT: begin
				rad_q <= {rad_q[45:0], 2'b00};
				if (srem_sh >= trial) begin
					srem_q <= srem_sh - trial;
					res_q  <= {res_q[22:0], 1'b1};
				end else begin
					srem_q <= srem_sh;
					res_q  <= {res_q[22:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done = (st_q == DS_DONE);
	assign root = (res_q[23:16] != 8'd0) ? 16'hFFFF : res_q[15:0];
endmodule

>>> design/curve_and_lead_speed_limiter.sv
// Top level of the curve and lead speed limiter.
// Depends on clls_pkg, clls_if (clls_in_if, clls_out_if) and clls_divsqrt.
//
//  channel   dir   payload                                   transfer when
//  in_ch     in    in_item_t (pose, speeds, coef, obstacle)  valid & ready
//  out_ch    out   out_item_t (target_speed, flags)          valid & ready
//  cfg       in    we / idx / wdata, 16-bit registers        we high
//
// Sequence: the idle state takes the item; an obstacle adds 16 CORDIC steps,
// the gain multiply, the tests, the TTC product and the lead update; every
// item then has its frame check. A frame_last item on a curve adds a start
// state and the root unit's divide, square root and done, then the emit.
// One item is in flight at a time; the result waits in the output register.
// Reset clears the registers to their defaults and the lead state.
// A stalled output holds the block in the emit state until transferred.
module curve_and_lead_speed_limiter import clls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	clls_in_if.sink     in_ch,
	clls_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	state_t st_q, st_nx;

	logic [15:0] max_lat_q, half_w_q, ttc_q;
	logic [15:0] lead_min_q;
	logic        lead_seen_q;
	in_item_t    item_q;
	logic signed [35:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic [3:0]  step_q;
	logic signed [26:0] fwd_q, left_q;
	logic        cand_q;
	logic signed [34:0] ttc_prod_q;
	logic [15:0] vrel_q;
	logic        curve_q;
	logic [31:0] mag_q;
	out_item_t   res_q;
	logic        out_v_q;

	logic        accept;
	logic        ds_done;
	logic [15:0] ds_root;
	logic        ds_start;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	// config writes; unknown index dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lat_q <= 16'd768;
			half_w_q  <= 16'd512;
			ttc_q     <= 16'd1280;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAX_LAT: max_lat_q <= cfg_wdata;
				REG_HALF_W:  half_w_q  <= cfg_wdata;
				REG_TTC:     ttc_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE: if (accept)
				st_nx = in_ch.data.obstacle_valid ? ST_CORDIC : ST_CHECK_LAST;
			ST_CORDIC: if (step_q == 4'(CordicSteps - 1)) st_nx = ST_GAIN;
			ST_GAIN:  st_nx = ST_TEST;
			ST_TEST:  st_nx = ST_TTC;
			ST_TTC:   st_nx = ST_LEAD;
			ST_LEAD:  st_nx = ST_CHECK_LAST;
			ST_CHECK_LAST: st_nx = !item_q.frame_last ? ST_IDLE :
				(curve_q ? ST_DIV : ST_EMIT);
			ST_DIV:   st_nx = ST_SQRT;
			ST_SQRT:  if (ds_done) st_nx = ST_EMIT;
			ST_EMIT:  if (!out_v_q || out_ch.ready) st_nx = ST_IDLE;
			default:  st_nx = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ds_start = (st_q == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_nx;
	end

	// rotation inputs: quarter turns exact, residual into z
	// offsets reach 2^32 after scaling and grow by the CORDIC gain: 36 bits
	logic [15:0] back_ang, a_ang;
	logic [1:0]  quad;
	logic signed [35:0] dx0, dy0, rx0, ry0;
	always_comb begin
		back_ang = 16'd0 - in_ch.data.ego_heading;
		a_ang    = back_ang + 16'd8192;
		quad     = a_ang[15:14];
		dx0 = (36'($signed(in_ch.data.obstacle_x))
			- 36'($signed(in_ch.data.ego_x))) <<< 8;
		dy0 = (36'($signed(in_ch.data.obstacle_y))
			- 36'($signed(in_ch.data.ego_y))) <<< 8;
		case (quad)
			2'd0: begin rx0 = dx0;  ry0 = dy0;  end
			2'd1: begin rx0 = -dy0; ry0 = dx0;  end
			2'd2: begin rx0 = -dx0; ry0 = -dy0; end
			default: begin rx0 = dy0; ry0 = -dx0; end
		endcase
	end

	logic signed [35:0] tx, ty;
	logic signed [26:0] atan_s;
	assign tx = x_q >>> step_q;
	assign ty = y_q >>> step_q;
	assign atan_s = 27'(atan_entry(step_q));

	logic signed [52:0] gx, gy;
	assign gx = 53'(x_q) * 53'(GainInv);
	assign gy = 53'(y_q) * 53'(GainInv);

	logic [26:0] aleft;
	assign aleft = left_q[26] ? 27'(-left_q) : 27'(left_q);

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (accept) begin
				item_q <= in_ch.data;
				x_q    <= rx0;
				y_q    <= ry0;
				z_q    <= 26'(($signed({1'b0, a_ang[13:0]}) - 16'sd8192)) <<< 8;
				step_q <= '0;
				mag_q  <= in_ch.data.curve_coef[31] ? 32'(-in_ch.data.curve_coef)
					: 32'(in_ch.data.curve_coef);
			end
			ST_CORDIC: begin
				step_q <= step_q + 4'd1;
				if (!z_q[25]) begin
					x_q <= x_q - ty; y_q <= y_q + tx; z_q <= z_q - 26'(atan_s);
				end else begin
					x_q <= x_q + ty; y_q <= y_q - tx; z_q <= z_q + 26'(atan_s);
				end
			end
			ST_GAIN: begin
				fwd_q  <= 27'(gx >>> 24);
				left_q <= 27'(gy >>> 24);
			end
			ST_TEST: begin
				cand_q <= (aleft < {11'd0, half_w_q}) && (fwd_q > 27'sd0)
					&& (item_q.ego_speed > item_q.obstacle_speed);
				vrel_q <= item_q.ego_speed - item_q.obstacle_speed;
			end
			ST_TTC: ttc_prod_q <= $signed({3'd0, ttc_q * 32'(vrel_q)});
			default: ;
		endcase
	end

	always_comb curve_q = (mag_q > 32'(CurveEps));

	// lead state and result register
	logic [15:0] ref_v;
	always_comb begin
		ref_v = item_q.speed_cap;
		if (curve_q && ds_root < ref_v) ref_v = ds_root;
		if (lead_min_q < ref_v) ref_v = lead_min_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_min_q  <= 16'hFFFF;
			lead_seen_q <= 1'b0;
			out_v_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			if (st_q == ST_LEAD && cand_q
				&& ($signed({fwd_q, 8'd0}) < ttc_prod_q)) begin
				lead_seen_q <= 1'b1;
				if (item_q.obstacle_speed < lead_min_q) lead_min_q <= item_q.obstacle_speed;
			end
			// load a new result when the output register is free or drains now
			if (st_q == ST_EMIT && (!out_v_q || out_ch.ready)) begin
				out_v_q <= 1'b1;
				res_q   <= '{target_speed: ref_v, lead_found: lead_seen_q,
					curve_active: curve_q};
				lead_min_q  <= 16'hFFFF;
				lead_seen_q <= 1'b0;
			end else if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	clls_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ds_start),
		.accel  (max_lat_q),
		.mag    (mag_q),
		.done   (ds_done),
		.root   (ds_root)
	);

`ifndef SYNTHESIS
	// take input only while idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (st_q == ST_IDLE)) else $error("ready outside idle");
	// lead flag clears after a result is loaded
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && st_nx == ST_IDLE) |=> (!lead_seen_q && lead_min_q == 16'hFFFF))
		else $error("lead state not cleared");
	// a lead always lowers the minimum below all ones, and only a lead does
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		lead_seen_q == (lead_min_q != 16'hFFFF))
		else $error("lead state broken");
`endif
endmodule
